### rtl/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg
// Types, constants and helpers shared by the SBUS frame channel decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfcd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned STORE_DEPTH = 22;
    localparam int unsigned FRAME_W     = STORE_DEPTH * BYTE_W;
    localparam int unsigned CHANNELS    = 16;
    localparam int unsigned RAW_W       = 11;
    localparam int unsigned VALUE_W     = 12;
    localparam int unsigned INDEX_W     = 4;
    localparam int unsigned POS_W       = 5;
    localparam int unsigned CFG_W       = 11;

    localparam logic [POS_W-1:0] POS_IDLE  = POS_W'(0);
    localparam logic [POS_W-1:0] POS_FIRST = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(STORE_DEPTH);

    localparam logic [CFG_W-1:0] OFFSET_RESET = 11'd1024;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 11'd700;

    localparam logic [RAW_W-1:0] CENTRE_0 = 11'd995;
    localparam logic [RAW_W-1:0] CENTRE_1 = 11'd998;
    localparam logic [RAW_W-1:0] CENTRE_2 = 11'd1010;
    localparam logic [RAW_W-1:0] CENTRE_3 = 11'd1003;

    localparam logic [RAW_W-1:0] SW3_LO  = 11'd100;
    localparam logic [RAW_W-1:0] SW3_HI  = 11'd400;
    localparam logic [RAW_W-1:0] SW2_LO  = 11'd600;
    localparam logic [RAW_W-1:0] SW2_HI  = 11'd1400;
    localparam logic [RAW_W-1:0] SW1_LO  = 11'd1600;
    localparam logic [RAW_W-1:0] SW1_HI  = 11'd2000;
    localparam logic [RAW_W-1:0] SW_MID  = 11'd600;

    localparam logic [VALUE_W-1:0] CODE_1 = 12'd1;
    localparam logic [VALUE_W-1:0] CODE_2 = 12'd2;
    localparam logic [VALUE_W-1:0] CODE_3 = 12'd3;

    typedef enum logic {
        REG_VALUE_OFFSET = 1'b0,
        REG_ERROR_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] index;
        value_t             value;
        logic               error;
    } result_t;

    function automatic logic [RAW_W-1:0] stick_centre(input logic [1:0] k);
        logic [RAW_W-1:0] c;
        case (k)
            2'd0:    c = CENTRE_0;
            2'd1:    c = CENTRE_1;
            2'd2:    c = CENTRE_2;
            default: c = CENTRE_3;
        endcase
        return c;
    endfunction

endpackage

### rtl/sbus_frame_channel_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_channel_decoder
// Stores SBUS frame bytes 1 to 22 in a shift line of byte cells, decodes the
// sixteen channels once the frame is complete and drains them through a
// chain of result cells.
//
//   channel   direction  item                       width
//   s_        in         frame byte, start flag     tdata 8, tuser 1
//   m_        out        channel result, last flag  tdata 16, tuser 1, tlast
//   cfg_      in         register write             index 1, data 11
//
// One byte is taken per cycle while s_tready is high. After byte 22 the
// decoded frame is loaded into the result chain once the chain is empty or
// its last item leaves; channel 0 is offered on the next cycle and one
// channel leaves per cycle while m_tready is high. s_tready falls only
// while a decoded frame waits for the chain; a frame of 23 or more bytes
// hides the drain. Reset clears the byte position, pending-frame flag and result
// valid bits and presets the registers; the frame store needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbus_frame_channel_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    // s_tdata: frame_byte[7:0]
    input  logic [7:0]  s_tdata,
    // s_tuser: frame_start[0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // m_tdata: channel_index[3:0], channel_value[15:4]
    output logic [15:0] m_tdata,
    // m_tuser: frame_error[0]
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [10:0] cfg_wdata
);

    localparam int unsigned DEPTH = sfcd_pkg::STORE_DEPTH;
    localparam int unsigned NCH   = sfcd_pkg::CHANNELS;
    localparam int unsigned BW    = sfcd_pkg::BYTE_W;
    localparam int unsigned RW    = sfcd_pkg::RAW_W;
    localparam int unsigned VW    = sfcd_pkg::VALUE_W;

    logic [sfcd_pkg::CFG_W-1:0] offset_reg, offset_next;
    logic [sfcd_pkg::CFG_W-1:0] limit_reg, limit_next;
    logic [sfcd_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                       done_reg, done_next;

    logic                       in_acc;
    logic                       store_en;
    logic                       head_take;
    logic                       load_en;

    logic [BW-1:0]              store_q [DEPTH];
    logic [sfcd_pkg::FRAME_W-1:0] frame_vec;

    sfcd_pkg::result_t          decoded [NCH];
    sfcd_pkg::result_t          chain_q [NCH];

    logic [RW-1:0]              raw [NCH];
    sfcd_pkg::value_t           val [NCH];
    logic                       frame_err;

    // ---------------- registers ----------------
    always_comb begin
        offset_next = offset_reg;
        limit_next  = limit_reg;
        if (cfg_we) begin
            case (sfcd_pkg::cfg_reg_t'(cfg_index))
                sfcd_pkg::REG_VALUE_OFFSET: offset_next = cfg_wdata;
                sfcd_pkg::REG_ERROR_LIMIT:  limit_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- frame position ----------------
    assign in_acc   = s_tvalid && s_tready;
    assign store_en = in_acc && !s_tuser && (pos_reg != sfcd_pkg::POS_IDLE)
                      && (pos_reg <= sfcd_pkg::POS_LAST);

    always_comb begin
        pos_next  = pos_reg;
        done_next = done_reg && !load_en;
        if (in_acc) begin
            if (s_tuser) begin
                pos_next = sfcd_pkg::POS_FIRST;
            end else if (!store_en) begin
                pos_next = sfcd_pkg::POS_IDLE;
            end else if (pos_reg == sfcd_pkg::POS_LAST) begin
                pos_next  = sfcd_pkg::POS_IDLE;
                done_next = 1'b1;
            end else begin
                pos_next = pos_reg + sfcd_pkg::POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= sfcd_pkg::OFFSET_RESET;
            limit_reg  <= sfcd_pkg::LIMIT_RESET;
            pos_reg    <= sfcd_pkg::POS_IDLE;
            done_reg   <= 1'b0;
        end else begin
            offset_reg <= offset_next;
            limit_reg  <= limit_next;
            pos_reg    <= pos_next;
            done_reg   <= done_next;
        end
    end

    assign s_tready = !done_reg || load_en;

    // ---------------- frame store shift line ----------------
    for (genvar i = 0; i < DEPTH; i++) begin : g_store
        logic [BW-1:0] cell_in;
        if (i == DEPTH - 1) begin : g_top
            assign cell_in = s_tdata;
        end else begin : g_mid
            assign cell_in = store_q[i+1];
        end
        sfcd_byte_cell u_cell (
            .aclk     (aclk),
            .shift_en (store_en),
            .byte_in  (cell_in),
            .byte_out (store_q[i])
        );
        assign frame_vec[i*BW +: BW] = store_q[i];
    end

    // ---------------- channel decode ----------------
    always_comb begin
        logic signed [VW-1:0] diff;
        logic        [VW-1:0] mag;
        frame_err = 1'b0;
        for (int k = 0; k < NCH; k++) begin
            raw[k] = frame_vec[k*RW +: RW];
            val[k] = sfcd_pkg::value_t'({1'b0, raw[k]});
        end
        for (int k = 0; k < 4; k++) begin
            diff = sfcd_pkg::value_t'({1'b0, sfcd_pkg::stick_centre(2'(k))})
                 - sfcd_pkg::value_t'({1'b0, raw[k]});
            mag  = diff[VW-1] ? VW'(-diff) : VW'(diff);
            if (mag > {1'b0, limit_reg}) begin
                frame_err = 1'b1;
            end
            val[k] = diff;
        end
        if (raw[4] inside {[sfcd_pkg::SW3_LO + 11'd1 : sfcd_pkg::SW3_HI - 11'd1]}) begin
            val[4] = sfcd_pkg::CODE_3;
        end else if (raw[4] inside
                     {[sfcd_pkg::SW2_LO + 11'd1 : sfcd_pkg::SW2_HI - 11'd1]}) begin
            val[4] = sfcd_pkg::CODE_2;
        end else if (raw[4] inside
                     {[sfcd_pkg::SW1_LO + 11'd1 : sfcd_pkg::SW1_HI - 11'd1]}) begin
            val[4] = sfcd_pkg::CODE_1;
        end else begin
            frame_err = 1'b1;
        end
        if (raw[5] < sfcd_pkg::SW_MID) begin
            val[5] = sfcd_pkg::CODE_1;
        end else if (raw[5] > sfcd_pkg::SW_MID) begin
            val[5] = sfcd_pkg::CODE_2;
        end else begin
            frame_err = 1'b1;
        end
        if (raw[7] < sfcd_pkg::SW_MID) begin
            val[7] = sfcd_pkg::CODE_1;
        end else if (raw[7] > sfcd_pkg::SW_MID) begin
            val[7] = sfcd_pkg::CODE_2;
        end else begin
            frame_err = 1'b1;
        end
        if (raw[9] > limit_reg) begin
            frame_err = 1'b1;
        end
        for (int k = 10; k < NCH; k++) begin
            val[k] = sfcd_pkg::value_t'({1'b0, raw[k]})
                   - sfcd_pkg::value_t'({1'b0, offset_reg});
        end
        for (int k = 0; k < NCH; k++) begin
            decoded[k].valid = 1'b1;
            decoded[k].index = sfcd_pkg::INDEX_W'(k);
            decoded[k].value = frame_err ? '0 : val[k];
            decoded[k].error = frame_err;
        end
    end

    // ---------------- result chain ----------------
    assign head_take = chain_q[0].valid && m_tready;
    assign load_en   = done_reg && (!chain_q[0].valid || (head_take && m_tlast));

    for (genvar k = 0; k < NCH; k++) begin : g_chain
        sfcd_pkg::result_t next_item;
        if (k == NCH - 1) begin : g_end
            assign next_item = '0;
        end else begin : g_mid
            assign next_item = chain_q[k+1];
        end
        sfcd_result_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .load_en  (load_en),
            .shift_en (head_take),
            .load_in  (decoded[k]),
            .next_in  (next_item),
            .item_out (chain_q[k])
        );
    end

    assign m_tvalid = chain_q[0].valid;
    assign m_tdata  = {chain_q[0].value, chain_q[0].index};
    assign m_tuser  = chain_q[0].error;
    assign m_tlast  = (chain_q[0].index == sfcd_pkg::INDEX_W'(NCH - 1));

endmodule

### rtl/sfcd_byte_cell.sv
// ----------------------------------------------------------------------------
// sfcd_byte_cell
// One stage of the frame store shift line: takes its neighbour's byte on shift.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcd_byte_cell (
    input  logic                        aclk,
    input  logic                        shift_en,
    input  logic [sfcd_pkg::BYTE_W-1:0] byte_in,
    output logic [sfcd_pkg::BYTE_W-1:0] byte_out
);

    logic [sfcd_pkg::BYTE_W-1:0] byte_reg;
    logic [sfcd_pkg::BYTE_W-1:0] byte_next;

    always_comb begin
        byte_next = shift_en ? byte_in : byte_reg;
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_out = byte_reg;

endmodule

### rtl/sfcd_result_cell.sv
// ----------------------------------------------------------------------------
// sfcd_result_cell
// One stage of the result chain: loads a decoded channel or takes its
// neighbour's item when the head item leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcd_result_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load_en,
    input  logic                shift_en,
    input  sfcd_pkg::result_t   load_in,
    input  sfcd_pkg::result_t   next_in,
    output sfcd_pkg::result_t   item_out
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [sfcd_pkg::INDEX_W-1:0] index_reg;
    logic [sfcd_pkg::INDEX_W-1:0] index_next;
    sfcd_pkg::value_t           value_reg;
    sfcd_pkg::value_t           value_next;
    logic                       error_reg;
    logic                       error_next;

    always_comb begin
        valid_next = valid_reg;
        index_next = index_reg;
        value_next = value_reg;
        error_next = error_reg;
        if (load_en) begin
            valid_next = load_in.valid;
            index_next = load_in.index;
            value_next = load_in.value;
            error_next = load_in.error;
        end else if (shift_en) begin
            valid_next = next_in.valid;
            index_next = next_in.index;
            value_next = next_in.value;
            error_next = next_in.error;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        index_reg <= index_next;
        value_reg <= value_next;
        error_reg <= error_next;
    end

    always_comb begin
        item_out.valid = valid_reg;
        item_out.index = index_reg;
        item_out.value = value_reg;
        item_out.error = error_reg;
    end

endmodule

### rtl/sfcd_checker.sv
// ----------------------------------------------------------------------------
// sfcd_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfcd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        m_tvalid,
    input logic        m_tready
);

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result item changed");

    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[15:4] == 12'd0)
        else $error("error item carries a non-zero value");

    a_run_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[3:0] == ($past(m_tdata[3:0]) + 4'd1))
            && (m_tuser == $past(m_tuser)))
        else $error("channel run broken");

    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[3:0] == 4'd15)))
        else $error("last flag not on channel fifteen");

endmodule

bind sbus_frame_channel_decoder sfcd_checker u_sfcd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

### test/tb_sbus_frame_channel_decoder.sv
// ----------------------------------------------------------------------------
// tb_sbus_frame_channel_decoder
// Feeds SBUS frames byte by byte into the channel decoder: an edge-value
// frame with a stray byte and a restarted header, then random frames
// (mostly well formed, some with out-of-band sticks or switches, broken
// frames, noise and trailing bytes) under several register settings. A
// scoreboard tracks the frame position, decodes each completed frame and
// checks the sixteen channel items field by field. Both sides idle at
// random; one long receiver hold-off forces the decoder to stall its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sbus_frame_channel_decoder;

    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 71;
    localparam int EDGE_FRAME_RAW [sfcd_pkg::CHANNELS] = '{
        295, 1698, 1010, 303, 101, 599, 2047, 601,
        0, 700, 0, 2047, 1024, 1, 2046, 1365
    };

    typedef struct packed {
        logic [sfcd_pkg::INDEX_W-1:0] index;
        sfcd_pkg::value_t             value;
        logic                         error;
        logic                         last;
    } channel_item_t;

    class sbus_channel_tracker;
        int            value_offset;
        int            error_limit;
        int            position;
        logic [7:0]    frame_bytes [sfcd_pkg::STORE_DEPTH];
        channel_item_t pending_channels [$];
        int            centre [4];
        int            errors;
        int            frames;
        int            error_frames;
        int            checked;

        function new();
            value_offset = int'(sfcd_pkg::OFFSET_RESET);
            error_limit  = int'(sfcd_pkg::LIMIT_RESET);
            position     = 0;
            centre[0]    = int'(sfcd_pkg::CENTRE_0);
            centre[1]    = int'(sfcd_pkg::CENTRE_1);
            centre[2]    = int'(sfcd_pkg::CENTRE_2);
            centre[3]    = int'(sfcd_pkg::CENTRE_3);
            errors       = 0;
            frames       = 0;
            error_frames = 0;
            checked      = 0;
        endfunction

        function void note_byte(logic [7:0] b, logic start);
            if (start) begin
                position = 1;
            end else if (position != 0) begin
                frame_bytes[position-1] = b;
                if (position == sfcd_pkg::STORE_DEPTH) begin
                    position = 0;
                    decode_frame();
                end else begin
                    position++;
                end
            end
        endfunction

        function void decode_frame();
            logic [sfcd_pkg::FRAME_W-1:0] bits;
            int                           v [sfcd_pkg::CHANNELS];
            bit                           err;
            channel_item_t                item;
            err = 1'b0;
            for (int i = 0; i < sfcd_pkg::STORE_DEPTH; i++) begin
                bits[i*sfcd_pkg::BYTE_W +: sfcd_pkg::BYTE_W] = frame_bytes[i];
            end
            for (int k = 0; k < sfcd_pkg::CHANNELS; k++) begin
                v[k] = int'(bits[k*sfcd_pkg::RAW_W +: sfcd_pkg::RAW_W]);
            end
            for (int k = 0; k < 4; k++) begin
                v[k] = centre[k] - v[k];
                if (v[k] > error_limit || -v[k] > error_limit) err = 1'b1;
            end
            if (v[4] > 100 && v[4] < 400) v[4] = 3;
            else if (v[4] > 600 && v[4] < 1400) v[4] = 2;
            else if (v[4] > 1600 && v[4] < 2000) v[4] = 1;
            else err = 1'b1;
            for (int k = 5; k <= 7; k += 2) begin
                if (v[k] < 600) v[k] = 1;
                else if (v[k] > 600) v[k] = 2;
                else err = 1'b1;
            end
            if (v[9] > error_limit) err = 1'b1;
            for (int k = 10; k < sfcd_pkg::CHANNELS; k++) v[k] = v[k] - value_offset;
            frames++;
            if (err) error_frames++;
            for (int k = 0; k < sfcd_pkg::CHANNELS; k++) begin
                item.index = sfcd_pkg::INDEX_W'(k);
                item.value = err ? '0 : sfcd_pkg::VALUE_W'(v[k]);
                item.error = err;
                item.last  = (k == sfcd_pkg::CHANNELS - 1);
                pending_channels.push_back(item);
            end
        endfunction

        function void compare(string what, int expected, int actual);
            if (expected != actual) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, expected, actual);
                errors++;
            end
        endfunction

        function void check_channel(logic [sfcd_pkg::INDEX_W-1:0] index,
                                    sfcd_pkg::value_t value,
                                    logic error, logic last);
            channel_item_t exp;
            if (pending_channels.size() == 0) begin
                $display("%0t: unexpected channel item, expected none, %s %0d value %0d",
                         $time, "actual index", index, value);
                errors++;
            end else begin
                exp = pending_channels.pop_front();
                checked++;
                compare("channel_index", int'(exp.index), int'(index));
                compare("channel_value", int'(exp.value), int'(value));
                compare("frame_error", int'(exp.error), int'(error));
                compare("last_channel", int'(exp.last), int'(last));
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_we;
    logic        cfg_index;
    logic [10:0] cfg_wdata;

    sbus_channel_tracker tracker;
    bit no_gaps;
    bit rx_steady;
    bit hold_req;
    int items_sent;
    int useful_items;
    int settings_used;
    int holds_done;

    sbus_frame_channel_decoder i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #1_000_000;
        $display("tb_sbus_frame_channel_decoder: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                tracker.check_channel(m_tdata[3:0], m_tdata[15:4], m_tuser, m_tlast);
            end
            if (s_tvalid && s_tready) begin
                tracker.note_byte(s_tdata, s_tuser);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else if (hold_req) begin
                hold_req = 1'b0;
                holds_done++;
                stall = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else if (rx_steady || $urandom_range(0, 99) < 75) begin
                m_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0) stall--;
            end
        end
    end

    function automatic logic [sfcd_pkg::RAW_W-1:0] pick_raw(int k, bit clean);
        int lim;
        int c;
        int lo;
        int hi;
        int r;
        int x;
        lim = tracker.error_limit;
        r   = $urandom_range(0, 99);
        if (k < 4) begin
            c  = tracker.centre[k];
            lo = (c - lim < 0) ? 0 : c - lim;
            hi = (c + lim > 2047) ? 2047 : c + lim;
            if (clean) begin
                if (r < 15) return sfcd_pkg::RAW_W'(lo);
                if (r < 30) return sfcd_pkg::RAW_W'(hi);
                return sfcd_pkg::RAW_W'($urandom_range(lo, hi));
            end
            if (r < 35 && c - lim - 1 >= 0) return sfcd_pkg::RAW_W'(c - lim - 1);
            if (r < 70 && c + lim + 1 <= 2047) return sfcd_pkg::RAW_W'(c + lim + 1);
            return sfcd_pkg::RAW_W'($urandom_range(0, 2047));
        end
        if (k == 4) begin
            if (clean) begin
                case ($urandom_range(0, 2))
                    0:       begin lo = 101;  hi = 399;  end
                    1:       begin lo = 601;  hi = 1399; end
                    default: begin lo = 1601; hi = 1999; end
                endcase
                if (r < 15) return sfcd_pkg::RAW_W'(lo);
                if (r < 30) return sfcd_pkg::RAW_W'(hi);
                return sfcd_pkg::RAW_W'($urandom_range(lo, hi));
            end
            case ($urandom_range(0, 8))
                0:       return sfcd_pkg::RAW_W'(100);
                1:       return sfcd_pkg::RAW_W'(400);
                2:       return sfcd_pkg::RAW_W'(600);
                3:       return sfcd_pkg::RAW_W'(1400);
                4:       return sfcd_pkg::RAW_W'(1600);
                5:       return sfcd_pkg::RAW_W'(2000);
                6:       return sfcd_pkg::RAW_W'(0);
                7:       return sfcd_pkg::RAW_W'(2047);
                default: return sfcd_pkg::RAW_W'($urandom_range(0, 2047));
            endcase
        end
        if (k == 5 || k == 7) begin
            if (clean) begin
                if (r < 20) return sfcd_pkg::RAW_W'(599);
                if (r < 40) return sfcd_pkg::RAW_W'(601);
                do x = $urandom_range(0, 2047); while (x == 600);
                return sfcd_pkg::RAW_W'(x);
            end
            if (r < 60) return sfcd_pkg::RAW_W'(600);
            return sfcd_pkg::RAW_W'($urandom_range(0, 2047));
        end
        if (k == 9) begin
            if (clean) begin
                if (r < 20) return sfcd_pkg::RAW_W'(lim);
                return sfcd_pkg::RAW_W'($urandom_range(0, lim));
            end
            if (r < 60 && lim < 2047) return sfcd_pkg::RAW_W'(lim + 1);
            return sfcd_pkg::RAW_W'($urandom_range(0, 2047));
        end
        if (r < 15) return sfcd_pkg::RAW_W'(0);
        if (r < 30) return sfcd_pkg::RAW_W'(2047);
        return sfcd_pkg::RAW_W'($urandom_range(0, 2047));
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic start, input bit counted);
        int gap;
        s_tdata  <= b;
        s_tuser  <= start;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (counted) useful_items++;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_stored_bytes(input logic [sfcd_pkg::FRAME_W-1:0] bits);
        for (int i = 0; i < sfcd_pkg::STORE_DEPTH; i++) begin
            send_byte(bits[i*sfcd_pkg::BYTE_W +: sfcd_pkg::BYTE_W], 1'b0, 1'b1);
        end
    endtask

    task automatic send_frame(input bit clean);
        logic [sfcd_pkg::FRAME_W-1:0] bits;
        int                           n;
        for (int k = 0; k < sfcd_pkg::CHANNELS; k++) begin
            bits[k*sfcd_pkg::RAW_W +: sfcd_pkg::RAW_W] =
                pick_raw(k, clean || $urandom_range(0, 99) >= 30);
        end
        if (!no_gaps && $urandom_range(0, 99) < 30) begin
            n = $urandom_range(1, 2);
            repeat (n) send_byte(8'($urandom), 1'b0, 1'b0);
        end
        send_byte(8'($urandom), 1'b1, 1'b1);
        if (!no_gaps && $urandom_range(0, 99) < 12) begin
            n = $urandom_range(0, sfcd_pkg::STORE_DEPTH - 1);
            repeat (n) send_byte(8'($urandom), 1'b0, 1'b1);
            send_byte(8'($urandom), 1'b1, 1'b1);
        end
        send_stored_bytes(bits);
        if ($urandom_range(0, 99) < 50) begin
            send_byte(8'($urandom), 1'b0, 1'b0);
            if ($urandom_range(0, 1) == 1) send_byte(8'h00, 1'b0, 1'b0);
        end
    endtask

    task automatic drain_channels();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending_channels.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input sfcd_pkg::cfg_reg_t r,
                             input logic [sfcd_pkg::CFG_W-1:0] v);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (r == sfcd_pkg::REG_VALUE_OFFSET) tracker.value_offset = int'(v);
        else tracker.error_limit = int'(v);
    endtask

    initial begin
        logic [sfcd_pkg::FRAME_W-1:0] edge_bits;
        logic [sfcd_pkg::CFG_W-1:0]   offsets [PHASES];
        logic [sfcd_pkg::CFG_W-1:0]   limits [PHASES];
        int                           target;
        tracker       = new();
        aresetn       = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        s_tvalid      = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = sfcd_pkg::REG_VALUE_OFFSET;
        cfg_wdata     = '0;
        no_gaps       = 1'b0;
        rx_steady     = 1'b0;
        hold_req      = 1'b0;
        items_sent    = 0;
        useful_items  = 0;
        settings_used = 1;
        holds_done    = 0;
        offsets[0] = sfcd_pkg::OFFSET_RESET;
        limits[0]  = sfcd_pkg::LIMIT_RESET;
        offsets[1] = '0;
        limits[1]  = '0;
        offsets[2] = '1;
        limits[2]  = '1;
        offsets[3] = sfcd_pkg::CFG_W'($urandom);
        limits[3]  = sfcd_pkg::CFG_W'($urandom_range(200, 900));
        offsets[4] = sfcd_pkg::CFG_W'($urandom);
        limits[4]  = sfcd_pkg::CFG_W'($urandom);
        for (int k = 0; k < sfcd_pkg::CHANNELS; k++) begin
            edge_bits[k*sfcd_pkg::RAW_W +: sfcd_pkg::RAW_W] =
                sfcd_pkg::RAW_W'(EDGE_FRAME_RAW[k]);
        end

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // stray byte while idle, then a header restart inside a frame
        send_byte(8'hA5, 1'b0, 1'b0);
        send_byte(8'h0F, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hF0, 1'b1, 1'b1);
        send_stored_bytes(edge_bits);
        send_byte(8'h00, 1'b0, 1'b0);

        target = useful_items;
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                drain_channels();
                write_reg(sfcd_pkg::REG_VALUE_OFFSET, offsets[p]);
                write_reg(sfcd_pkg::REG_ERROR_LIMIT, limits[p]);
                settings_used++;
            end
            target += PHASE_ITEMS;
            if (p == 2) begin
                no_gaps   = 1'b1;
                rx_steady = 1'b1;
                send_frame(1'b1);
                no_gaps   = 1'b0;
                rx_steady = 1'b0;
            end
            if (p == 3) begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                repeat (3) send_frame($urandom_range(0, 99) < 70);
                no_gaps  = 1'b0;
            end
            while (useful_items < target) send_frame($urandom_range(0, 99) < 70);
        end
        drain_channels();
        repeat (12) @(posedge aclk);

        $display("%0d bytes sent, %0d frames decoded (%0d flagged as errors), %s %0d",
                 items_sent, tracker.frames, tracker.error_frames, "channels checked",
                 tracker.checked);
        $display("%0d register settings used, %0d long receiver hold-off(s)",
                 settings_used, holds_done);
        if (tracker.errors == 0 && tracker.pending_channels.size() == 0) begin
            $display("tb_sbus_frame_channel_decoder: done, clean");
        end else begin
            $display("tb_sbus_frame_channel_decoder: done, errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/sfcd_pkg.sv
rtl/sfcd_byte_cell.sv
rtl/sfcd_result_cell.sv
rtl/sbus_frame_channel_decoder.sv
rtl/sfcd_checker.sv
test/tb_sbus_frame_channel_decoder.sv
